// ----- rtl/core/bace_pkg.sv -----
// Shared types, widths and constants of the blind adaptive complex equalizer.
package bace_pkg;

    localparam int TAPS    = 13;
    localparam int CENTRE  = TAPS / 2;
    localparam int SMP_W   = 16;
    localparam int WGT_W   = 24;
    localparam int MU_W    = 16;
    localparam int ERR_W   = 17;
    localparam int MAG2_W  = 32;
    localparam int QUO_W   = 15;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = SMP_W + WGT_W;
    localparam int UPD_LAT = 3;
    localparam int CNT_W   = $clog2(TAPS + UPD_LAT + 17);
    localparam int WARM_W  = $clog2(TAPS + 1);
    localparam int ADDR_W  = 3;

    localparam logic [MU_W-1:0]         MU_RESET = 16'd3277;
    localparam logic signed [WGT_W-1:0] W_ONE    = 24'sd4194304;

    // Register index, taken from paddr[2].
    localparam logic REG_STEP_SIZE = 1'b0;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_smp;

    typedef struct packed {
        logic signed [WGT_W-1:0] re;
        logic signed [WGT_W-1:0] im;
    } t_wgt;

    typedef struct packed {
        logic push;
        logic rot;
    } t_cell_ctl;

endpackage

// ----- rtl/core/bace_cell.sv -----
// One cell of the rotating tap chain: one delayed sample and its weight.
module bace_cell import bace_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_smp      i_smp,
    input  t_wgt      i_wgt,
    input  t_wgt      i_init_wgt,
    output t_smp      o_smp,
    output t_wgt      o_wgt
);

    t_smp r_smp;
    t_wgt r_wgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
            r_wgt <= i_init_wgt;
        end else begin
            // A push shifts samples only; a rotation moves the whole pair.
            if (i_ctl.push || i_ctl.rot) begin
                r_smp <= i_smp;
            end
            if (i_ctl.rot) begin
                r_wgt <= i_wgt;
            end
        end
    end

    assign o_smp = r_smp;
    assign o_wgt = r_wgt;

endmodule

// ----- rtl/core/bace_err.sv -----
// Iterative modulus error unit: integer square root, then two restoring dividers.
module bace_err import bace_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SMP_W-1:0] i_r_re,
    input  logic signed [SMP_W-1:0] i_r_im,
    output logic                    o_done,
    output logic signed [ERR_W-1:0] o_e_re,
    output logic signed [ERR_W-1:0] o_e_im
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SQRT = 2'd1;
    localparam logic [1:0] E_DIV  = 2'd2;
    localparam logic [1:0] E_DONE = 2'd3;

    logic [1:0]              r_state;
    logic [3:0]              r_cnt;
    logic [MAG2_W-1:0]       r_x;
    logic [MAG2_W-1:0]       r_res;
    logic [MAG2_W-1:0]       r_bit;
    logic [SMP_W-1:0]        r_rem_re, r_rem_im;
    logic [QUO_W-1:0]        r_dq_re, r_dq_im;
    logic [QUO_W-1:0]        r_q_re, r_q_im;
    logic signed [ERR_W-1:0] r_e_re, r_e_im;

    logic [SMP_W-1:0]        abs_re, abs_im;
    logic [MAG2_W-1:0]       sq_re, sq_im, sq_sum;
    logic [SMP_W-1:0]        mag;
    logic [SMP_W:0]          t_re, t_im;
    logic                    ge_re, ge_im;
    logic signed [ERR_W-1:0] qs_re, qs_im;

    assign abs_re = i_r_re[SMP_W-1] ? SMP_W'(-i_r_re) : SMP_W'(i_r_re);
    assign abs_im = i_r_im[SMP_W-1] ? SMP_W'(-i_r_im) : SMP_W'(i_r_im);
    assign sq_re  = MAG2_W'(abs_re) * MAG2_W'(abs_re);
    assign sq_im  = MAG2_W'(abs_im) * MAG2_W'(abs_im);
    assign sq_sum = r_res + r_bit;
    assign mag    = r_res[SMP_W-1:0];

    assign t_re  = {r_rem_re, r_dq_re[QUO_W-1]};
    assign t_im  = {r_rem_im, r_dq_im[QUO_W-1]};
    assign ge_re = t_re >= {1'b0, mag};
    assign ge_im = t_im >= {1'b0, mag};

    assign qs_re = i_r_re[SMP_W-1] ? -ERR_W'(r_q_re) : ERR_W'(r_q_re);
    assign qs_im = i_r_im[SMP_W-1] ? -ERR_W'(r_q_im) : ERR_W'(r_q_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state <= E_SQRT;
                        r_cnt   <= '0;
                    end
                end
                E_SQRT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= E_DIV;
                        r_cnt   <= '0;
                    end
                end
                E_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(QUO_W - 1)) begin
                        r_state <= E_DONE;
                    end
                end
                E_DONE: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                r_x   <= sq_re + sq_im;
                r_res <= '0;
                r_bit <= MAG2_W'(1) << (MAG2_W - 2);
            end
            E_SQRT: begin
                if (r_x >= sq_sum) begin
                    r_x   <= r_x - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                // Dividend is |part| * 2^14; its upper part already sits below |r|.
                r_rem_re <= SMP_W'(abs_re[SMP_W-1:1]);
                r_rem_im <= SMP_W'(abs_im[SMP_W-1:1]);
                r_dq_re  <= {abs_re[0], 14'd0};
                r_dq_im  <= {abs_im[0], 14'd0};
                r_q_re   <= '0;
                r_q_im   <= '0;
            end
            E_DIV: begin
                r_rem_re <= ge_re ? SMP_W'(t_re - {1'b0, mag}) : SMP_W'(t_re);
                r_rem_im <= ge_im ? SMP_W'(t_im - {1'b0, mag}) : SMP_W'(t_im);
                r_dq_re  <= r_dq_re << 1;
                r_dq_im  <= r_dq_im << 1;
                r_q_re   <= {r_q_re[QUO_W-2:0], ge_re};
                r_q_im   <= {r_q_im[QUO_W-2:0], ge_im};
            end
            E_DONE: begin
                if (mag == '0) begin
                    r_e_re <= '0;
                    r_e_im <= '0;
                end else begin
                    r_e_re <= ERR_W'(i_r_re) - qs_re;
                    r_e_im <= ERR_W'(i_r_im) - qs_im;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == E_DONE);
    assign o_e_re = r_e_re;
    assign o_e_im = r_e_im;

endmodule

// ----- rtl/core/blind_adaptive_complex_equalizer_top.sv -----
// Top level of the blind adaptive complex equalizer: tap chain, MAC and sequencer.
//
// Usage: received complex samples arrive on the s_axis channel, one request per
// sample (tdata = sample_re in bits 15:0, sample_im in bits 31:16). Each request
// yields exactly one equalized sample on the m_axis channel with the same packing.
// The adaptation step size is written through the APB port at byte address 0.
//
// The taps live in a chain of cells that rotates past one shared complex MAC.
// Each sample goes, from acceptance to readiness for the next, through the
// filter state, a rounding state and an output-load state, then (after
// warm-up) 16 square-root steps and 15 divide steps in the error unit plus a
// finishing state, and the weight-update state, where the update pipeline
// forms extra places in the rotating ring. The result is loaded onto m_axis in
// the output-load state. During the first TAPS samples no adaptation runs and
// the error and update states are skipped.
//
// Reset clears the delay line, sets the centre weight to 1.0 and the others to
// zero, restores the step size and restarts the warm-up. When the receiver
// stalls, the result waits in the output register and the block holds before
// loading the next result; a new input is taken while the old result waits.
module blind_adaptive_complex_equalizer_top import bace_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,  // sample_re [15:0], sample_im [31:16]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,  // eq_re [15:0], eq_im [31:16]
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILT  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [WARM_W-1:0] r_warm;
    logic [MU_W-1:0]   r_mu;

    // Filter MAC.
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3, r_p4;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [SMP_W-1:0]  r_r_re, r_r_im;

    // Output register.
    logic              r_ovalid;
    logic [31:0]       r_odata;

    // Weight update pipeline, which joins the ring during the update pass.
    t_smp                         r_u1_smp, r_u2_smp, r_u3_smp;
    t_wgt                         r_u1_wgt, r_u2_wgt, r_u3_wgt;
    logic signed [ERR_W+SMP_W-1:0] r_a1, r_a2, r_a3, r_a4;
    logic signed [ERR_W+SMP_W:0]   r_pr, r_pi;
    logic signed [ERR_W+SMP_W+MU_W+1:0] r_m_re, r_m_im;

    logic                    accept, cfg_wr, load_out, err_start, err_done;
    logic signed [ERR_W-1:0] e_re, e_im;
    t_cell_ctl               ctl;
    t_smp                    smp_o [TAPS];
    t_wgt                    wgt_o [TAPS];
    t_smp                    tail_smp;
    t_wgt                    tail_wgt, upd_wgt;
    t_smp                    in_smp;

    logic signed [ACC_W-23:0]           rnd_re, rnd_im;
    logic signed [ERR_W+SMP_W+MU_W-20:0] d_re, d_im;

    // Saturate a rounded accumulator to a 16-bit sample.
    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [ACC_W-23:0] v);
        if (v > (ACC_W-22)'(32767)) begin
            return 16'sh7fff;
        end else if (v < -(ACC_W-22)'(32768)) begin
            return 16'sh8000;
        end
        return SMP_W'(v);
    endfunction

    // Subtract a rounded correction from a weight part and saturate to 24 bits.
    function automatic logic signed [WGT_W-1:0] upd_part(
        input logic signed [WGT_W-1:0]             w,
        input logic signed [ERR_W+SMP_W+MU_W-20:0] d
    );
        logic signed [ERR_W+SMP_W+MU_W-18:0] s;
        s = (ERR_W+SMP_W+MU_W-17)'(w) - (ERR_W+SMP_W+MU_W-17)'(d);
        if (s > (ERR_W+SMP_W+MU_W-17)'(8388607)) begin
            return 24'sh7fffff;
        end else if (s < -(ERR_W+SMP_W+MU_W-17)'(8388608)) begin
            return 24'sh800000;
        end
        return WGT_W'(s);
    endfunction

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign load_out = (r_state == ST_OUT) && (!r_ovalid || i_m_axis_tready);
    assign err_start = load_out && (r_warm == WARM_W'(TAPS));
    assign in_smp   = '{re: i_s_axis_tdata[15:0], im: i_s_axis_tdata[31:16]};

    // Chain control: a push shifts in the new sample, a rotation cycles the ring.
    assign ctl.push = accept;
    assign ctl.rot  = ((r_state == ST_FILT) && (r_cnt < CNT_W'(TAPS))) || (r_state == ST_UPD);

    // The update pipeline output closes the ring in the update pass.
    assign d_re    = (ERR_W+SMP_W+MU_W-19)'((r_m_re + 52'sd2097152) >>> 22);
    assign d_im    = (ERR_W+SMP_W+MU_W-19)'((r_m_im + 52'sd2097152) >>> 22);
    assign upd_wgt = '{re: upd_part(r_u3_wgt.re, d_re), im: upd_part(r_u3_wgt.im, d_im)};

    always_comb begin
        if (r_state == ST_UPD) begin
            tail_smp = r_u3_smp;
            tail_wgt = upd_wgt;
        end else if (r_state == ST_FILT) begin
            tail_smp = smp_o[0];
            tail_wgt = wgt_o[0];
        end else begin
            tail_smp = in_smp;
            tail_wgt = wgt_o[0];
        end
    end

    // Cell i holds weight i and the sample of age TAPS-1-i; cell 0 is the head.
    for (genvar gi = 0; gi < TAPS; gi++) begin : g_cell
        t_wgt init_w;
        t_smp nb_smp;
        t_wgt nb_wgt;
        assign init_w = (gi == CENTRE) ? t_wgt'{re: W_ONE, im: '0} : t_wgt'('0);
        if (gi == TAPS - 1) begin : g_tail
            assign nb_smp = tail_smp;
            assign nb_wgt = tail_wgt;
        end else begin : g_mid
            assign nb_smp = smp_o[gi+1];
            assign nb_wgt = wgt_o[gi+1];
        end
        bace_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_smp      (nb_smp),
            .i_wgt      (nb_wgt),
            .i_init_wgt (init_w),
            .o_smp      (smp_o[gi]),
            .o_wgt      (wgt_o[gi])
        );
    end

    bace_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (err_start),
        .i_r_re  (r_r_re),
        .i_r_im  (r_r_im),
        .o_done  (err_done),
        .o_e_re  (e_re),
        .o_e_im  (e_im)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_warm   <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_FILT) && (r_cnt < CNT_W'(TAPS));
            if (r_ovalid && i_m_axis_tready && !load_out) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_FILT;
                        r_cnt   <= '0;
                    end
                end
                ST_FILT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(TAPS)) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_ovalid <= 1'b1;
                        if (r_warm == WARM_W'(TAPS)) begin
                            r_state <= ST_ERR;
                        end else begin
                            r_warm  <= r_warm + WARM_W'(1);
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ERR: begin
                    if (err_done) begin
                        r_state <= ST_UPD;
                        r_cnt   <= '0;
                    end
                end
                ST_UPD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(TAPS + UPD_LAT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Filter datapath: products of the head pair, then accumulate.
    assign rnd_re = (ACC_W-22)'((r_acc_re + 48'sd2097152) >>> 22);
    assign rnd_im = (ACC_W-22)'((r_acc_im + 48'sd2097152) >>> 22);

    always_ff @(posedge i_clk) begin
        r_p1 <= PROD_W'(smp_o[0].re) * PROD_W'(wgt_o[0].re);
        r_p2 <= PROD_W'(smp_o[0].im) * PROD_W'(wgt_o[0].im);
        r_p3 <= PROD_W'(smp_o[0].im) * PROD_W'(wgt_o[0].re);
        r_p4 <= PROD_W'(smp_o[0].re) * PROD_W'(wgt_o[0].im);
        if (accept) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_pv) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p1) + ACC_W'(r_p2);
            r_acc_im <= r_acc_im + ACC_W'(r_p3) - ACC_W'(r_p4);
        end
        if (r_state == ST_ROUND) begin
            r_r_re <= sat_smp(rnd_re);
            r_r_im <= sat_smp(rnd_im);
        end
        if (load_out) begin
            r_odata <= {r_r_im, r_r_re};
        end
    end

    // Update pipeline: conj(e) * sample, then times mu; advances in every update cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_u1_smp <= smp_o[0];
            r_u1_wgt <= wgt_o[0];
            r_a1 <= (ERR_W+SMP_W)'(e_re) * (ERR_W+SMP_W)'(smp_o[0].re);
            r_a2 <= (ERR_W+SMP_W)'(e_im) * (ERR_W+SMP_W)'(smp_o[0].im);
            r_a3 <= (ERR_W+SMP_W)'(e_re) * (ERR_W+SMP_W)'(smp_o[0].im);
            r_a4 <= (ERR_W+SMP_W)'(e_im) * (ERR_W+SMP_W)'(smp_o[0].re);
            r_u2_smp <= r_u1_smp;
            r_u2_wgt <= r_u1_wgt;
            r_pr <= (ERR_W+SMP_W+1)'(r_a1) + (ERR_W+SMP_W+1)'(r_a2);
            r_pi <= (ERR_W+SMP_W+1)'(r_a3) - (ERR_W+SMP_W+1)'(r_a4);
            r_u3_smp <= r_u2_smp;
            r_u3_wgt <= r_u2_wgt;
            r_m_re <= (ERR_W+SMP_W+MU_W+2)'(r_pr)
                    * (ERR_W+SMP_W+MU_W+2)'($signed({1'b0, r_mu}));
            r_m_im <= (ERR_W+SMP_W+MU_W+2)'(r_pi)
                    * (ERR_W+SMP_W+MU_W+2)'($signed({1'b0, r_mu}));
        end
    end

    // Configuration port.
    assign cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= MU_RESET;
        end else if (cfg_wr && (i_paddr[2] == REG_STEP_SIZE)) begin
            r_mu <= i_pwdata[MU_W-1:0];
        end
    end

    assign o_prdata        = (i_paddr[2] == REG_STEP_SIZE) ? {16'd0, r_mu} : 32'd0;
    assign o_pready        = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // An accepted sample always starts a filter pass.
    a_accept_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_FILT))
        else $error("accepted sample did not start the filter pass");

    // The error unit only finishes while the sequencer waits for it.
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        err_done |-> (r_state == ST_ERR))
        else $error("error unit finished outside the error wait");

    // A loaded result shows the rounded filter output.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_m_axis_tvalid && (o_m_axis_tdata == $past({r_r_im, r_r_re}))))
        else $error("output register did not take the filter result");

endmodule
